>>> hdl/sit_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection test package
// Shared coordinate, vector and product types, the per-stage payload structs
// and the small helper functions that the pipeline stages use.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
  } dvec_t;

  // The two partial products of one cross product, lhs minus rhs.
  typedef struct packed {
    prod_t lhs;
    prod_t rhs;
  } pterm_t;

  typedef struct packed {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
  } seg_pair_t;

  typedef struct packed {
    logic intersects;
    logic parallel;
  } seg_result_t;

  // Endpoints after ordering: p0 <= p1 and p2 <= p3 lexicographically.
  typedef struct packed {
    point_t p0;
    point_t p1;
    point_t p2;
    point_t p3;
  } sorted_t;

  typedef struct packed {
    dvec_t d1;      // p0 - p1
    dvec_t d2;      // p2 - p3
    dvec_t e2;      // p0 - p2
    dvec_t e3;      // p0 - p3
    dvec_t f2;      // p1 - p2
    logic  shared;  // some endpoint of one segment equals one of the other
    logic  overlap; // ordered ranges overlap
  } diffs_t;

  typedef struct packed {
    pterm_t cr_dir;    // d1 x d2
    pterm_t cr_d1_e3;  // d1 x e3
    pterm_t cr_d1_e2;  // d1 x e2
    pterm_t cr_d2_e2;  // d2 x e2
    pterm_t cr_f2_d2;  // f2 x d2
    logic   shared;
    logic   overlap;
  } prods_t;

  function automatic logic lex_lt(point_t a, point_t b);
    return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

  function automatic logic pt_eq(point_t a, point_t b);
    return (a.x == b.x) && (a.y == b.y);
  endfunction

  function automatic dvec_t vec_sub(point_t a, point_t b);
    dvec_t v;
    v.x = DIFF_BITS'(a.x) - DIFF_BITS'(b.x);
    v.y = DIFF_BITS'(a.y) - DIFF_BITS'(b.y);
    return v;
  endfunction

  function automatic pterm_t cross_terms(dvec_t a, dvec_t b);
    pterm_t t;
    t.lhs = PROD_BITS'(a.x) * PROD_BITS'(b.y);
    t.rhs = PROD_BITS'(a.y) * PROD_BITS'(b.x);
    return t;
  endfunction

endpackage

>>> hdl/segment_intersection_test.sv
// ----------------------------------------------------------------------------
// Segment intersection test
// Reports whether two integer line segments share a point, and whether
// their directions are parallel, using exact cross-product signs.
//
//   channel   signals                            payload
//   pair      pair_valid, pair_ready, pair       seg_pair_t, eight coordinates
//   result    result_valid, result_ready, result seg_result_t, two flags
//
// One pair enters per cycle while the result side keeps up. Four register
// stages (order, differences, products, signs) sit between the channels, so
// a pair passes through all four registers before result_valid rises.
// Each stage holds its own valid bit and refills as soon as its contents move
// on, so bubbles are squeezed out when the result side stalls.
// A stall on the result side holds every full stage; pair_ready falls only
// when all four stages are full. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module segment_intersection_test import sit_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pair_valid,
  output logic        pair_ready,
  input  seg_pair_t   pair,
  output logic        result_valid,
  input  logic        result_ready,
  output seg_result_t result
);

  logic    sort_valid, sort_ready;
  sorted_t sort_data;
  logic    diff_valid, diff_ready;
  diffs_t  diff_data;
  logic    mult_valid, mult_ready;
  prods_t  mult_data;

  sit_sort u_sort (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pair_valid),
    .up_ready (pair_ready),
    .up_data  (pair),
    .dn_valid (sort_valid),
    .dn_ready (sort_ready),
    .dn_data  (sort_data)
  );

  sit_diff u_diff (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sort_valid),
    .up_ready (sort_ready),
    .up_data  (sort_data),
    .dn_valid (diff_valid),
    .dn_ready (diff_ready),
    .dn_data  (diff_data)
  );

  sit_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .up_valid (diff_valid),
    .up_ready (diff_ready),
    .up_data  (diff_data),
    .dn_valid (mult_valid),
    .dn_ready (mult_ready),
    .dn_data  (mult_data)
  );

  sit_decide u_decide (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mult_valid),
    .up_ready (mult_ready),
    .up_data  (mult_data),
    .dn_valid (result_valid),
    .dn_ready (result_ready),
    .dn_data  (result)
  );

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !pair_ready |-> (sort_valid && diff_valid && mult_valid && result_valid &&
                     !result_ready))
    else $error("input blocked while the pipeline has room");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> (!sort_valid && !diff_valid && !mult_valid && !result_valid))
    else $error("pipeline not empty after reset");

endmodule

>>> hdl/sit_sort.sv
// ----------------------------------------------------------------------------
// Endpoint ordering stage
// Orders the two endpoints of each segment by x, then y, and registers them.
// ----------------------------------------------------------------------------
module sit_sort import sit_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_ready,
  input  seg_pair_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output sorted_t   dn_data
);

  point_t  a0, a1, b0, b1;
  sorted_t sorted_next;

  always_comb begin
    a0 = '{x: up_data.first_start_x,  y: up_data.first_start_y};
    a1 = '{x: up_data.first_end_x,    y: up_data.first_end_y};
    b0 = '{x: up_data.second_start_x, y: up_data.second_start_y};
    b1 = '{x: up_data.second_end_x,   y: up_data.second_end_y};
    if (lex_lt(a1, a0)) begin
      sorted_next.p0 = a1;
      sorted_next.p1 = a0;
    end else begin
      sorted_next.p0 = a0;
      sorted_next.p1 = a1;
    end
    if (lex_lt(b1, b0)) begin
      sorted_next.p2 = b1;
      sorted_next.p3 = b0;
    end else begin
      sorted_next.p2 = b0;
      sorted_next.p3 = b1;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= sorted_next;
    end
  end

endmodule

>>> hdl/sit_diff.sv
// ----------------------------------------------------------------------------
// Difference stage
// Forms the direction and offset vectors and the endpoint order flags.
// ----------------------------------------------------------------------------
module sit_diff import sit_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    up_valid,
  output logic    up_ready,
  input  sorted_t up_data,
  output logic    dn_valid,
  input  logic    dn_ready,
  output diffs_t  dn_data
);

  diffs_t diffs_next;

  always_comb begin
    diffs_next.d1 = vec_sub(up_data.p0, up_data.p1);
    diffs_next.d2 = vec_sub(up_data.p2, up_data.p3);
    diffs_next.e2 = vec_sub(up_data.p0, up_data.p2);
    diffs_next.e3 = vec_sub(up_data.p0, up_data.p3);
    diffs_next.f2 = vec_sub(up_data.p1, up_data.p2);
    diffs_next.shared = pt_eq(up_data.p0, up_data.p2) || pt_eq(up_data.p0, up_data.p3) ||
                        pt_eq(up_data.p1, up_data.p2) || pt_eq(up_data.p1, up_data.p3);
    // Either the second segment starts inside the first, or the first starts
    // inside the second.
    diffs_next.overlap =
      (!lex_lt(up_data.p2, up_data.p0) && !lex_lt(up_data.p1, up_data.p2)) ||
      (!lex_lt(up_data.p0, up_data.p2) && !lex_lt(up_data.p3, up_data.p0));
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= diffs_next;
    end
  end

endmodule

>>> hdl/sit_mult.sv
// ----------------------------------------------------------------------------
// Product stage
// Computes the partial products of the five cross products and registers
// them before the subtraction.
// ----------------------------------------------------------------------------
module sit_mult import sit_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   up_valid,
  output logic   up_ready,
  input  diffs_t up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output prods_t dn_data
);

  prods_t prods_next;

  always_comb begin
    prods_next.cr_dir   = cross_terms(up_data.d1, up_data.d2);
    prods_next.cr_d1_e3 = cross_terms(up_data.d1, up_data.e3);
    prods_next.cr_d1_e2 = cross_terms(up_data.d1, up_data.e2);
    prods_next.cr_d2_e2 = cross_terms(up_data.d2, up_data.e2);
    prods_next.cr_f2_d2 = cross_terms(up_data.f2, up_data.d2);
    prods_next.shared   = up_data.shared;
    prods_next.overlap  = up_data.overlap;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= prods_next;
    end
  end

endmodule

>>> hdl/sit_decide.sv
// ----------------------------------------------------------------------------
// Decision stage
// Finishes the cross products, takes their signs and registers the result.
// ----------------------------------------------------------------------------
module sit_decide import sit_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  prods_t      up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output seg_result_t dn_data
);

  cross_t      c_dir, c_a, c_b, c_c, c_d;
  logic        z_a, z_b, z_c, z_d;
  logic        n_a, n_b, n_c, n_d;
  logic        p_a, p_b, p_c, p_d;
  logic        s12_neg, s12_le0, s34_neg, s34_le0;
  logic        par, col;
  seg_result_t result_next;

  always_comb begin
    c_dir = CROSS_BITS'(up_data.cr_dir.lhs)   - CROSS_BITS'(up_data.cr_dir.rhs);
    c_a   = CROSS_BITS'(up_data.cr_d1_e3.lhs) - CROSS_BITS'(up_data.cr_d1_e3.rhs);
    c_b   = CROSS_BITS'(up_data.cr_d1_e2.lhs) - CROSS_BITS'(up_data.cr_d1_e2.rhs);
    c_c   = CROSS_BITS'(up_data.cr_d2_e2.lhs) - CROSS_BITS'(up_data.cr_d2_e2.rhs);
    c_d   = CROSS_BITS'(up_data.cr_f2_d2.lhs) - CROSS_BITS'(up_data.cr_f2_d2.rhs);

    z_a = (c_a == '0);
    z_b = (c_b == '0);
    z_c = (c_c == '0);
    z_d = (c_d == '0);
    n_a = c_a[CROSS_BITS-1];
    n_b = c_b[CROSS_BITS-1];
    n_c = c_c[CROSS_BITS-1];
    n_d = c_d[CROSS_BITS-1];
    p_a = !n_a && !z_a;
    p_b = !n_b && !z_b;
    p_c = !n_c && !z_c;
    p_d = !n_d && !z_d;

    par = (c_dir == '0);
    col = z_a && z_c;

    // The third test uses e2 x d2, the negation of d2 x e2, so its product
    // with the fourth is negative when both raw signs agree.
    s12_neg = (p_b && n_a) || (n_b && p_a);
    s12_le0 = s12_neg || z_a || z_b;
    s34_neg = (p_c && p_d) || (n_c && n_d);
    s34_le0 = s34_neg || z_c || z_d;

    result_next.parallel = par;
    if (up_data.shared) begin
      result_next.intersects = 1'b1;
    end else if (par) begin
      result_next.intersects = col && up_data.overlap;
    end else begin
      result_next.intersects = (s12_neg && s34_le0) || (s12_le0 && s34_neg);
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= result_next;
    end
  end

  a_shared_hits: assert property (@(posedge clk) disable iff (rst)
    (up_valid && up_ready && up_data.shared) |=> (dn_valid && dn_data.intersects))
    else $error("shared endpoint did not report an intersection");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Segment intersection test bench
// Drives segment pairs through the pair channel and checks every result
// against an exact-integer model of the cross-product test. The run covers
// corner cases, random traffic with idle bursts on both sides, a long
// result-side hold-off, a drain pause and a final full-rate stretch.
// ----------------------------------------------------------------------------
module tb;
  import sit_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PIPE_LATENCY   = 4;

  typedef struct {
    longint x;
    longint y;
  } xy_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pair_valid = 1'b0;
  logic        pair_ready;
  seg_pair_t   pair = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  seg_result_t result;

  seg_result_t expected_q[$];
  int          pairs_sent = 0;
  int          results_checked = 0;
  int          mismatches = 0;
  int          hit_count = 0;
  int          par_count = 0;

  // Receiver controls: the bench toggles hold_go to ask for a long hold-off.
  bit rx_idle_en = 1'b0;
  bit tx_idle_en = 1'b0;
  bit hold_go = 1'b0;
  bit hold_ack = 1'b0;
  int hold_len = 0;
  int hold_left = 0;
  int rx_stall = 0;
  int idle_cycles = 0;

  segment_intersection_test u_dut (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_valid),
    .pair_ready   (pair_ready),
    .pair         (pair),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Exact-integer prediction
  // ---------------------------------------------------------------------------
  function automatic int lex_cmp(xy_t a, xy_t b);
    if (a.x != b.x) return (a.x < b.x) ? -1 : 1;
    if (a.y != b.y) return (a.y < b.y) ? -1 : 1;
    return 0;
  endfunction

  function automatic int cross_sgn(longint ax, longint ay, longint bx, longint by);
    longint c;
    c = ax * by - ay * bx;
    return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
  endfunction

  function automatic seg_result_t predict_pair(seg_pair_t p);
    xy_t a0, a1, b0, b1, t;
    longint d1x, d1y, d2x, d2y;
    bit par, hit, col, ovl;
    int s1, s2, s3, s4, s12, s34;
    seg_result_t r;
    a0.x = p.first_start_x;   a0.y = p.first_start_y;
    a1.x = p.first_end_x;     a1.y = p.first_end_y;
    b0.x = p.second_start_x;  b0.y = p.second_start_y;
    b1.x = p.second_end_x;    b1.y = p.second_end_y;
    if (lex_cmp(a0, a1) > 0) begin
      t = a0; a0 = a1; a1 = t;
    end
    if (lex_cmp(b0, b1) > 0) begin
      t = b0; b0 = b1; b1 = t;
    end
    d1x = a0.x - a1.x;  d1y = a0.y - a1.y;
    d2x = b0.x - b1.x;  d2y = b0.y - b1.y;
    par = (cross_sgn(d1x, d1y, d2x, d2y) == 0);
    if (lex_cmp(a0, b0) == 0 || lex_cmp(a0, b1) == 0 ||
        lex_cmp(a1, b0) == 0 || lex_cmp(a1, b1) == 0) begin
      hit = 1'b1;
    end else if (par) begin
      // A zero-length segment only counts when it lies on the other line.
      col = (cross_sgn(d1x, d1y, a0.x - b1.x, a0.y - b1.y) == 0) &&
            (cross_sgn(d2x, d2y, a0.x - b0.x, a0.y - b0.y) == 0);
      ovl = (lex_cmp(a0, b0) <= 0 && lex_cmp(b0, a1) <= 0) ||
            (lex_cmp(b0, a0) <= 0 && lex_cmp(a0, b1) <= 0);
      hit = col && ovl;
    end else begin
      s1 = cross_sgn(d1x, d1y, a0.x - b0.x, a0.y - b0.y);
      s2 = cross_sgn(d1x, d1y, a0.x - b1.x, a0.y - b1.y);
      s3 = cross_sgn(a0.x - b0.x, a0.y - b0.y, d2x, d2y);
      s4 = cross_sgn(a1.x - b0.x, a1.y - b0.y, d2x, d2y);
      s12 = s1 * s2;
      s34 = s3 * s4;
      hit = (s12 < 0 && s34 <= 0) || (s12 <= 0 && s34 < 0);
    end
    r.intersects = hit;
    r.parallel   = par;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic seg_pair_t make_pair(int ax, int ay, int bx, int by,
                                          int cx, int cy, int dx, int dy);
    seg_pair_t p;
    p = {coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by),
         coord_t'(cx), coord_t'(cy), coord_t'(dx), coord_t'(dy)};
    return p;
  endfunction

  function automatic int rand_span(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      6: return 32767;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic seg_pair_t random_pair();
    int c[8];
    int kind, bx, by, dx, dy, k, m, ox, oy, src, dst;
    kind = $urandom_range(0, 7);
    case (kind)
      0, 1: begin
        for (k = 0; k < 8; k++) c[k] = int'($urandom_range(0, 65535)) - 32768;
      end
      2: begin
        for (k = 0; k < 8; k++) c[k] = rand_span(-8, 8);
      end
      3, 4, 5: begin
        // Points on one line; the parallel variant shifts the second segment.
        bx = rand_span(-1000, 1000);
        by = rand_span(-1000, 1000);
        dx = rand_span(-20, 20);
        dy = rand_span(-20, 20);
        ox = (kind == 5) ? rand_span(-3, 3) : 0;
        oy = (kind == 5) ? rand_span(-3, 3) : 0;
        for (k = 0; k < 4; k++) begin
          m = rand_span(-10, 10);
          c[2*k]   = bx + m * dx + ((k >= 2) ? ox : 0);
          c[2*k+1] = by + m * dy + ((k >= 2) ? oy : 0);
        end
      end
      6: begin
        for (k = 0; k < 8; k++) begin
          c[k] = $urandom_range(0, 1) ? rand_span(-50, 50)
                                      : int'($urandom_range(0, 65535)) - 32768;
        end
        src = $urandom_range(0, 1);
        dst = $urandom_range(2, 3);
        c[2*dst]   = c[2*src];
        c[2*dst+1] = c[2*src+1];
      end
      default: begin
        for (k = 0; k < 8; k++) c[k] = extreme_coord();
      end
    endcase
    return make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  // Offers one pair and returns at the edge where it is transferred.
  task automatic send_pair(input seg_pair_t p);
    int gap;
    seg_result_t r;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      pair_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pair       <= p;
    pair_valid <= 1'b1;
    do @(posedge clk); while (!pair_ready);
    r = predict_pair(p);
    expected_q.push_back(r);
    pairs_sent++;
    hit_count += r.intersects;
    par_count += r.parallel;
  endtask

  task automatic wait_results_drained();
    pair_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_corner_cases();
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(make_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
    send_pair(make_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
    send_pair(make_pair(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768));
    send_pair(make_pair(-32768, -32768, 32767, 32766, 32767, 32767, -32767, -32768));
    // Shared endpoint, collinear and not.
    send_pair(make_pair(0, 0, 5, 5, 5, 5, 10, 10));
    send_pair(make_pair(0, 0, 5, 0, 5, 0, 5, 5));
    send_pair(make_pair(3, 4, 9, -2, 3, 4, 9, -2));
    // Zero-length segments, off the line and on it.
    send_pair(make_pair(3, 3, 3, 3, 0, 0, 10, 0));
    send_pair(make_pair(5, 0, 5, 0, 0, 0, 10, 0));
    send_pair(make_pair(0, 0, 10, 0, 20, 0, 20, 0));
    // Collinear: partial overlap, disjoint, second containing first.
    send_pair(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
    send_pair(make_pair(0, 0, 4, 0, 6, 0, 9, 0));
    send_pair(make_pair(3, 0, 5, 0, 0, 0, 10, 0));
    send_pair(make_pair(10, 0, 0, 0, 15, 0, 5, 0));
    send_pair(make_pair(0, 5, 0, -5, 0, 8, 0, 3));
    // Parallel, distinct lines.
    send_pair(make_pair(0, 0, 10, 0, 0, 1, 10, 1));
    // Proper crossing, touch on the interior, and a miss.
    send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
    send_pair(make_pair(0, 0, 10, 0, 5, 7, 5, 0));
    send_pair(make_pair(0, 0, 1, 1, 5, 0, 6, -3));
    send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int count);
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    repeat (count) send_pair(random_pair());
  endtask

  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    hold_len <= 100;
    hold_go  <= ~hold_go;
    // The pipeline fills during the hold and pair_ready drops.
    repeat (30) send_pair(random_pair());
  endtask

  task automatic test_drain_pause();
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    repeat (50) send_pair(random_pair());
    wait_results_drained();
    repeat (50) send_pair(random_pair());
  endtask

  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    repeat (250) send_pair(random_pair());
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, checker, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_go != hold_ack) begin
      hold_ack     <= hold_go;
      hold_left    <= hold_len;
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall     <= rx_stall - 1;
      result_ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
      rx_stall     <= $urandom_range(0, 11);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    seg_result_t want;
    if (!rst && result_valid && result_ready) begin
      results_checked++;
      if (expected_q.size() == 0) begin
        $error("result transfer with no pair outstanding: intersects %0b parallel %0b",
               result.intersects, result.parallel);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (result.intersects !== want.intersects) begin
          $error("intersects mismatch: expected %0b, actual %0b",
                 want.intersects, result.intersects);
          mismatches++;
        end
        if (result.parallel !== want.parallel) begin
          $error("parallel mismatch: expected %0b, actual %0b",
                 want.parallel, result.parallel);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pair_valid && pair_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_cases();
    test_random_traffic(400);
    test_output_backpressure();
    test_drain_pause();
    test_random_traffic(300);
    test_full_rate();
    wait_results_drained();
    repeat (PIPE_LATENCY + 6) @(posedge clk);
    $display("Sent %0d segment pairs (%0d intersecting, %0d parallel), checked %0d results.",
             pairs_sent, hit_count, par_count, results_checked);
    $display("%s", "Phases: corner cases, idling traffic, long result hold-off, drain pause, full rate.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/sit_pkg.sv
hdl/sit_sort.sv
hdl/sit_diff.sv
hdl/sit_mult.sv
hdl/sit_decide.sv
hdl/segment_intersection_test.sv
bench/tb.sv
